// ----- sv/exlex_pkg.sv -----
// Shared types, token and mode codes, and character tables for the expression lexer.
`default_nettype none
package exlex_pkg;

  // Field widths
  localparam int CharW   = 8;
  localparam int KindW   = 5;
  localparam int StartW  = 16;
  localparam int LenW    = 16;
  localparam int PosBits = 16;
  localparam int ModeW   = 4;

  // Result queue geometry
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};

  // Scanner modes
  localparam logic [ModeW-1:0] MODE_IDLE  = 4'd0;
  localparam logic [ModeW-1:0] MODE_INT   = 4'd1;
  localparam logic [ModeW-1:0] MODE_IDENT = 4'd2;
  localparam logic [ModeW-1:0] MODE_MINUS = 4'd3;
  localparam logic [ModeW-1:0] MODE_COLON = 4'd4;
  localparam logic [ModeW-1:0] MODE_EQ    = 4'd5;
  localparam logic [ModeW-1:0] MODE_BANG  = 4'd6;
  localparam logic [ModeW-1:0] MODE_GT    = 4'd7;
  localparam logic [ModeW-1:0] MODE_LT    = 4'd8;

  // Token kinds
  localparam logic [KindW-1:0] TK_END     = 5'd0;
  localparam logic [KindW-1:0] TK_INT     = 5'd1;
  localparam logic [KindW-1:0] TK_IDENT   = 5'd2;
  localparam logic [KindW-1:0] TK_PLUS    = 5'd3;
  localparam logic [KindW-1:0] TK_MINUS   = 5'd4;
  localparam logic [KindW-1:0] TK_ARROW   = 5'd5;
  localparam logic [KindW-1:0] TK_STAR    = 5'd6;
  localparam logic [KindW-1:0] TK_SLASH   = 5'd7;
  localparam logic [KindW-1:0] TK_LCURLY  = 5'd8;
  localparam logic [KindW-1:0] TK_RCURLY  = 5'd9;
  localparam logic [KindW-1:0] TK_LROUND  = 5'd10;
  localparam logic [KindW-1:0] TK_RROUND  = 5'd11;
  localparam logic [KindW-1:0] TK_COMMA   = 5'd12;
  localparam logic [KindW-1:0] TK_COLON   = 5'd13;
  localparam logic [KindW-1:0] TK_DECLARE = 5'd14;
  localparam logic [KindW-1:0] TK_REBIND  = 5'd15;
  localparam logic [KindW-1:0] TK_EQ      = 5'd16;
  localparam logic [KindW-1:0] TK_NOT     = 5'd17;
  localparam logic [KindW-1:0] TK_NEQ     = 5'd18;
  localparam logic [KindW-1:0] TK_GT      = 5'd19;
  localparam logic [KindW-1:0] TK_GEQ     = 5'd20;
  localparam logic [KindW-1:0] TK_LT      = 5'd21;
  localparam logic [KindW-1:0] TK_LEQ     = 5'd22;
  localparam logic [KindW-1:0] TK_INVALID = 5'd23;

  // Characters
  localparam logic [CharW-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CharW-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CharW-1:0] CH_GT     = 8'h3E;
  localparam logic [CharW-1:0] CH_LT     = 8'h3C;
  localparam logic [CharW-1:0] CH_EQ     = 8'h3D;
  localparam logic [CharW-1:0] CH_BANG   = 8'h21;
  localparam logic [CharW-1:0] CH_STAR   = 8'h2A;
  localparam logic [CharW-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CharW-1:0] CH_LCURLY = 8'h7B;
  localparam logic [CharW-1:0] CH_RCURLY = 8'h7D;
  localparam logic [CharW-1:0] CH_LROUND = 8'h28;
  localparam logic [CharW-1:0] CH_RROUND = 8'h29;
  localparam logic [CharW-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CharW-1:0] CH_COLON  = 8'h3A;

  typedef struct packed {
    logic [CharW-1:0] char_byte;
    logic             end_marker;
  } exlex_in_t;

  typedef struct packed {
    logic [KindW-1:0]  token_kind;
    logic [StartW-1:0] token_start;
    logic [LenW-1:0]   token_length;
    logic              last_of_run;
  } exlex_tok_t;

  // Tokens produced by one request, in output order
  typedef struct packed {
    logic       push0;
    logic       push1;
    exlex_tok_t tok0;
    exlex_tok_t tok1;
  } exlex_push_t;

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [CharW-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_op_mode(input logic [ModeW-1:0] m);
    return (m >= MODE_MINUS) && (m <= MODE_LT);
  endfunction

  // Kind of a held operator when no pair forms
  function automatic logic [KindW-1:0] op_single_kind(input logic [ModeW-1:0] m);
    logic [KindW-1:0] k;
    case (m)
      MODE_MINUS: k = TK_MINUS;
      MODE_COLON: k = TK_COLON;
      MODE_EQ:    k = TK_REBIND;
      MODE_BANG:  k = TK_NOT;
      MODE_GT:    k = TK_GT;
      MODE_LT:    k = TK_LT;
      default:    k = TK_INVALID;
    endcase
    return k;
  endfunction

  // Second character that completes a held operator
  function automatic logic [CharW-1:0] op_pair_char(input logic [ModeW-1:0] m);
    return (m == MODE_MINUS) ? CH_GT : CH_EQ;
  endfunction

  function automatic logic [KindW-1:0] op_pair_kind(input logic [ModeW-1:0] m);
    logic [KindW-1:0] k;
    case (m)
      MODE_MINUS: k = TK_ARROW;
      MODE_COLON: k = TK_DECLARE;
      MODE_EQ:    k = TK_EQ;
      MODE_BANG:  k = TK_NEQ;
      MODE_GT:    k = TK_GEQ;
      MODE_LT:    k = TK_LEQ;
      default:    k = TK_INVALID;
    endcase
    return k;
  endfunction

  // Mode entered by a character that may start a pair, else idle
  function automatic logic [ModeW-1:0] hold_mode(input logic [CharW-1:0] c);
    logic [ModeW-1:0] m;
    case (c)
      CH_MINUS: m = MODE_MINUS;
      CH_COLON: m = MODE_COLON;
      CH_EQ:    m = MODE_EQ;
      CH_BANG:  m = MODE_BANG;
      CH_GT:    m = MODE_GT;
      CH_LT:    m = MODE_LT;
      default:  m = MODE_IDLE;
    endcase
    return m;
  endfunction

  // Kind of a single-character token that is emitted at once
  function automatic logic [KindW-1:0] single_kind(input logic [CharW-1:0] c);
    logic [KindW-1:0] k;
    case (c)
      CH_PLUS:   k = TK_PLUS;
      CH_STAR:   k = TK_STAR;
      CH_SLASH:  k = TK_SLASH;
      CH_LCURLY: k = TK_LCURLY;
      CH_RCURLY: k = TK_RCURLY;
      CH_LROUND: k = TK_LROUND;
      CH_RROUND: k = TK_RROUND;
      CH_COMMA:  k = TK_COMMA;
      default:   k = TK_INVALID;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ----- sv/exlex_scan.sv -----
// Scanner state and the per-byte token logic.
`default_nettype none
module exlex_scan (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   advance,
  input  exlex_pkg::exlex_in_t  req,
  output exlex_pkg::exlex_push_t push
);

  logic [exlex_pkg::ModeW-1:0]   mode_r, mode_nxt;
  logic [exlex_pkg::StartW-1:0]  pstart_r, pstart_nxt;
  logic [exlex_pkg::LenW-1:0]    plen_r, plen_nxt;
  logic [exlex_pkg::PosBits-1:0] pos_r, pos_nxt;

  logic [exlex_pkg::CharW-1:0]  c;
  logic [exlex_pkg::StartW-1:0] pos_start;
  logic                         dig, alp, spc;
  logic [exlex_pkg::LenW-1:0]   plen_inc;

  exlex_pkg::exlex_tok_t flush_tok, second_tok;
  logic                  flush_v, second_v;
  logic [exlex_pkg::ModeW-1:0] held;

  always_comb begin
    c         = req.char_byte;
    pos_start = exlex_pkg::StartW'(pos_r);
    dig       = exlex_pkg::is_digit(c);
    alp       = exlex_pkg::is_alpha(c);
    spc       = exlex_pkg::is_space(c);
    held      = exlex_pkg::hold_mode(c);
    plen_inc  = (plen_r == exlex_pkg::LenMax) ? plen_r : plen_r + 1'b1;

    // Token held in the state, if any
    flush_tok.token_start = pstart_r;
    flush_tok.last_of_run = 1'b0;
    flush_v = 1'b1;
    case (mode_r)
      exlex_pkg::MODE_INT: begin
        flush_tok.token_kind   = exlex_pkg::TK_INT;
        flush_tok.token_length = plen_r;
      end
      exlex_pkg::MODE_IDENT: begin
        flush_tok.token_kind   = exlex_pkg::TK_IDENT;
        flush_tok.token_length = plen_r;
      end
      default: begin
        flush_tok.token_kind   = exlex_pkg::op_single_kind(mode_r);
        flush_tok.token_length = exlex_pkg::LenW'(1);
        flush_v = exlex_pkg::is_op_mode(mode_r);
      end
    endcase

    second_tok.token_kind   = exlex_pkg::single_kind(c);
    second_tok.token_start  = pos_start;
    second_tok.token_length = exlex_pkg::LenW'(1);
    second_tok.last_of_run  = 1'b1;
    second_v   = 1'b0;
    mode_nxt   = mode_r;
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    pos_nxt    = pos_r + 1'b1;

    if (req.end_marker) begin
      // Flush, then end token; restart position
      second_tok.token_kind   = exlex_pkg::TK_END;
      second_tok.token_length = '0;
      second_v = 1'b1;
      mode_nxt = exlex_pkg::MODE_IDLE;
      plen_nxt = '0;
      pos_nxt  = '0;
    end else if ((mode_r == exlex_pkg::MODE_INT && dig) ||
                 (mode_r == exlex_pkg::MODE_IDENT && (dig || alp))) begin
      // Extend the run
      flush_v  = 1'b0;
      plen_nxt = plen_inc;
    end else if (exlex_pkg::is_op_mode(mode_r) && c == exlex_pkg::op_pair_char(mode_r)) begin
      // Complete a two-character operator
      flush_tok.token_kind   = exlex_pkg::op_pair_kind(mode_r);
      flush_tok.token_length = exlex_pkg::LenW'(2);
      mode_nxt = exlex_pkg::MODE_IDLE;
      plen_nxt = '0;
    end else begin
      // Flush, then scan the byte from idle
      mode_nxt = exlex_pkg::MODE_IDLE;
      plen_nxt = '0;
      if (spc) begin
        second_v = 1'b0;
      end else if (dig || alp) begin
        mode_nxt   = dig ? exlex_pkg::MODE_INT : exlex_pkg::MODE_IDENT;
        pstart_nxt = pos_start;
        plen_nxt   = exlex_pkg::LenW'(1);
      end else if (held != exlex_pkg::MODE_IDLE) begin
        mode_nxt   = held;
        pstart_nxt = pos_start;
        plen_nxt   = exlex_pkg::LenW'(1);
      end else begin
        second_v = 1'b1;
      end
    end

    // Pack in order; the last token of the request is marked
    push.push0 = flush_v || second_v;
    push.push1 = flush_v && second_v;
    push.tok0  = flush_v ? flush_tok : second_tok;
    push.tok0.last_of_run = !(flush_v && second_v);
    push.tok1  = second_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= exlex_pkg::MODE_IDLE;
      pstart_r <= '0;
      plen_r   <= '0;
      pos_r    <= '0;
    end else if (advance) begin
      mode_r   <= mode_nxt;
      pstart_r <= pstart_nxt;
      plen_r   <= plen_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/exlex_fifo.sv -----
// Small token queue: takes up to two tokens a cycle, hands out one.
`default_nettype none
module exlex_fifo (
  input  wire                     clk,
  input  wire                     rst_n,
  input  exlex_pkg::exlex_push_t  push,
  input  wire                     pop,
  output logic                    room2,
  output logic                    not_empty,
  output exlex_pkg::exlex_tok_t   head
);

  exlex_pkg::exlex_tok_t mem_r [exlex_pkg::FifoDepth];
  logic [exlex_pkg::FifoPtrW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [exlex_pkg::FifoCntW-1:0] cnt_r, cnt_nxt;
  logic [exlex_pkg::FifoPtrW-1:0] wp1;
  logic do_pop;

  always_comb begin
    do_pop    = pop && (cnt_r != '0);
    wp1       = wp_r + 1'b1;
    wp_nxt    = wp_r + exlex_pkg::FifoPtrW'(push.push0) + exlex_pkg::FifoPtrW'(push.push1);
    rp_nxt    = rp_r + exlex_pkg::FifoPtrW'(do_pop);
    cnt_nxt   = cnt_r + exlex_pkg::FifoCntW'(push.push0) + exlex_pkg::FifoCntW'(push.push1)
                - exlex_pkg::FifoCntW'(do_pop);
    room2     = cnt_r <= exlex_pkg::FifoCntW'(exlex_pkg::FifoDepth - 2);
    not_empty = cnt_r != '0;
    head      = mem_r[rp_r];
  end

  // Store tokens
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wp_r] <= push.tok0;
    end
    if (push.push1) begin
      mem_r[wp1] <= push.tok1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/expression_lexer.sv -----
// Expression lexer: byte stream in, tokens out through a small result queue.
// A token shows once the request that ends it has passed the input stage into the queue.
// One byte per cycle while the queue has room for two; a byte or end request may yield
// up to two tokens; they leave a four-entry queue at one per cycle while out_ready is high.
// Reset (synchronous, rst_n low): scanner idle, position zero, queue and input stage empty.
`default_nettype none
module expression_lexer (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  exlex_pkg::exlex_in_t   in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output exlex_pkg::exlex_tok_t  out_data
);

  logic                  in_v_r, in_v_nxt;
  exlex_pkg::exlex_in_t  in_d_r;
  logic                  advance, room2;
  exlex_pkg::exlex_push_t push, push_gated;

  // Process the held request when the queue can take two tokens
  always_comb begin
    advance  = in_v_r && room2;
    in_ready = !in_v_r || advance;
    in_v_nxt = in_ready ? in_valid : in_v_r;
    push_gated       = push;
    push_gated.push0 = push.push0 && advance;
    push_gated.push1 = push.push1 && advance;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_d_r <= in_data;
    end
  end

  exlex_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .req     (in_d_r),
    .push    (push)
  );

  exlex_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_gated),
    .pop       (out_ready),
    .room2     (room2),
    .not_empty (out_valid),
    .head      (out_data)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb_expression_lexer.sv -----
// Self-checking testbench for the expression lexer: directed text, random text, long runs.
`timescale 1ns / 100ps

module tb_expression_lexer;

  localparam int unsigned CycleLimit = 100000;
  localparam int          DrainCycles = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  exlex_pkg::exlex_in_t  in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  exlex_pkg::exlex_tok_t out_data;

  // Idle percentages of the sender and the receiver
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int          mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;

  // Lexer shadow state
  logic [exlex_pkg::ModeW-1:0]   scan_mode = exlex_pkg::MODE_IDLE;
  logic [exlex_pkg::StartW-1:0]  run_start = '0;
  logic [exlex_pkg::LenW-1:0]    run_length = '0;
  logic [exlex_pkg::PosBits-1:0] byte_pos = '0;

  // Tokens made by the current request, and tokens still owed by the block
  exlex_pkg::exlex_tok_t step_tokens[$];
  exlex_pkg::exlex_tok_t lexed_tokens[$];
  exlex_pkg::exlex_tok_t oldest_token;

  expression_lexer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Token shadow model
  // ---------------------------------------------------------------------------

  function automatic logic is_dec(input logic [exlex_pkg::CharW-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [exlex_pkg::CharW-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_blank(input logic [exlex_pkg::CharW-1:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_held(input logic [exlex_pkg::ModeW-1:0] m);
    return (m >= exlex_pkg::MODE_MINUS) && (m <= exlex_pkg::MODE_LT);
  endfunction

  // Kind of a held operator that stands alone
  function automatic logic [exlex_pkg::KindW-1:0] held_alone(
      input logic [exlex_pkg::ModeW-1:0] m);
    case (m)
      exlex_pkg::MODE_MINUS: return exlex_pkg::TK_MINUS;
      exlex_pkg::MODE_COLON: return exlex_pkg::TK_COLON;
      exlex_pkg::MODE_EQ:    return exlex_pkg::TK_REBIND;
      exlex_pkg::MODE_BANG:  return exlex_pkg::TK_NOT;
      exlex_pkg::MODE_GT:    return exlex_pkg::TK_GT;
      default:               return exlex_pkg::TK_LT;
    endcase
  endfunction

  // Kind of a held operator joined by its second character
  function automatic logic [exlex_pkg::KindW-1:0] held_paired(
      input logic [exlex_pkg::ModeW-1:0] m);
    case (m)
      exlex_pkg::MODE_MINUS: return exlex_pkg::TK_ARROW;
      exlex_pkg::MODE_COLON: return exlex_pkg::TK_DECLARE;
      exlex_pkg::MODE_EQ:    return exlex_pkg::TK_EQ;
      exlex_pkg::MODE_BANG:  return exlex_pkg::TK_NEQ;
      exlex_pkg::MODE_GT:    return exlex_pkg::TK_GEQ;
      default:               return exlex_pkg::TK_LEQ;
    endcase
  endfunction

  function automatic void note_token(input logic [exlex_pkg::KindW-1:0] kind,
                                     input logic [exlex_pkg::StartW-1:0] start,
                                     input logic [exlex_pkg::LenW-1:0] length);
    exlex_pkg::exlex_tok_t t;
    t.token_kind   = kind;
    t.token_start  = start;
    t.token_length = length;
    t.last_of_run  = 1'b0;
    step_tokens.push_back(t);
  endfunction

  // Emit whatever run or operator is held, then go idle
  function automatic void flush_held();
    if (scan_mode == exlex_pkg::MODE_INT) begin
      note_token(exlex_pkg::TK_INT, run_start, run_length);
    end else if (scan_mode == exlex_pkg::MODE_IDENT) begin
      note_token(exlex_pkg::TK_IDENT, run_start, run_length);
    end else if (is_held(scan_mode)) begin
      note_token(held_alone(scan_mode), run_start, 16'd1);
    end
    scan_mode  = exlex_pkg::MODE_IDLE;
    run_length = '0;
  endfunction

  // Scan a byte from the idle mode
  function automatic void scan_fresh(input logic [exlex_pkg::CharW-1:0] c);
    logic [exlex_pkg::ModeW-1:0] hold;
    logic [exlex_pkg::KindW-1:0] kind;
    hold = exlex_pkg::MODE_IDLE;
    kind = exlex_pkg::TK_INVALID;
    if (is_blank(c)) return;
    if (is_dec(c) || is_letter(c)) begin
      scan_mode  = is_dec(c) ? exlex_pkg::MODE_INT : exlex_pkg::MODE_IDENT;
      run_start  = byte_pos;
      run_length = 16'd1;
      return;
    end
    case (c)
      exlex_pkg::CH_MINUS:  hold = exlex_pkg::MODE_MINUS;
      exlex_pkg::CH_COLON:  hold = exlex_pkg::MODE_COLON;
      exlex_pkg::CH_EQ:     hold = exlex_pkg::MODE_EQ;
      exlex_pkg::CH_BANG:   hold = exlex_pkg::MODE_BANG;
      exlex_pkg::CH_GT:     hold = exlex_pkg::MODE_GT;
      exlex_pkg::CH_LT:     hold = exlex_pkg::MODE_LT;
      exlex_pkg::CH_PLUS:   kind = exlex_pkg::TK_PLUS;
      exlex_pkg::CH_STAR:   kind = exlex_pkg::TK_STAR;
      exlex_pkg::CH_SLASH:  kind = exlex_pkg::TK_SLASH;
      exlex_pkg::CH_LCURLY: kind = exlex_pkg::TK_LCURLY;
      exlex_pkg::CH_RCURLY: kind = exlex_pkg::TK_RCURLY;
      exlex_pkg::CH_LROUND: kind = exlex_pkg::TK_LROUND;
      exlex_pkg::CH_RROUND: kind = exlex_pkg::TK_RROUND;
      exlex_pkg::CH_COMMA:  kind = exlex_pkg::TK_COMMA;
      default:              kind = exlex_pkg::TK_INVALID;
    endcase
    if (hold != exlex_pkg::MODE_IDLE) begin
      scan_mode  = hold;
      run_start  = byte_pos;
      run_length = 16'd1;
    end else begin
      note_token(kind, byte_pos, 16'd1);
    end
  endfunction

  // Advance the shadow lexer by one accepted request and queue its tokens
  function automatic void lex_step(input exlex_pkg::exlex_in_t req);
    logic [exlex_pkg::CharW-1:0] c;
    c = req.char_byte;
    step_tokens.delete();
    if (req.end_marker) begin
      flush_held();
      note_token(exlex_pkg::TK_END, byte_pos, 16'd0);
      byte_pos = '0;
    end else begin
      if ((scan_mode == exlex_pkg::MODE_INT) && is_dec(c)) begin
        if (run_length != exlex_pkg::LenMax) run_length = run_length + 16'd1;
      end else if ((scan_mode == exlex_pkg::MODE_IDENT) && (is_dec(c) || is_letter(c))) begin
        if (run_length != exlex_pkg::LenMax) run_length = run_length + 16'd1;
      end else if (is_held(scan_mode) &&
                   (c == ((scan_mode == exlex_pkg::MODE_MINUS) ? exlex_pkg::CH_GT
                                                               : exlex_pkg::CH_EQ))) begin
        note_token(held_paired(scan_mode), run_start, 16'd2);
        scan_mode  = exlex_pkg::MODE_IDLE;
        run_length = '0;
      end else begin
        flush_held();
        scan_fresh(c);
      end
      byte_pos = byte_pos + 1'b1;
    end
    for (int i = 0; i < step_tokens.size(); i++) begin
      exlex_pkg::exlex_tok_t t;
      t = step_tokens[i];
      t.last_of_run = (i == step_tokens.size() - 1);
      lexed_tokens.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Idle at random, then hold the request until it is taken
  task automatic send_request(input exlex_pkg::exlex_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lex_step(req);
    requests_sent++;
  endtask

  task automatic send_char(input logic [exlex_pkg::CharW-1:0] c);
    exlex_pkg::exlex_in_t req;
    req.char_byte  = c;
    req.end_marker = 1'b0;
    send_request(req);
  endtask

  // The carried byte is junk on an end request
  task automatic send_end();
    exlex_pkg::exlex_in_t req;
    req.char_byte  = exlex_pkg::CharW'($urandom_range(255));
    req.end_marker = 1'b1;
    send_request(req);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Random text pieces
  // ---------------------------------------------------------------------------

  function automatic logic [exlex_pkg::CharW-1:0] random_letter();
    if ($urandom_range(1)) return exlex_pkg::CharW'("a" + $urandom_range(25));
    return exlex_pkg::CharW'("A" + $urandom_range(25));
  endfunction

  function automatic logic [exlex_pkg::CharW-1:0] random_digit();
    return exlex_pkg::CharW'("0" + $urandom_range(9));
  endfunction

  function automatic logic [exlex_pkg::CharW-1:0] random_blank();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? 8'h20 : exlex_pkg::CharW'(9 + r);
  endfunction

  function automatic logic [exlex_pkg::CharW-1:0] random_op_lead();
    case ($urandom_range(13))
      0:  return exlex_pkg::CH_PLUS;
      1:  return exlex_pkg::CH_MINUS;
      2:  return exlex_pkg::CH_STAR;
      3:  return exlex_pkg::CH_SLASH;
      4:  return exlex_pkg::CH_LCURLY;
      5:  return exlex_pkg::CH_RCURLY;
      6:  return exlex_pkg::CH_LROUND;
      7:  return exlex_pkg::CH_RROUND;
      8:  return exlex_pkg::CH_COMMA;
      9:  return exlex_pkg::CH_COLON;
      10: return exlex_pkg::CH_EQ;
      11: return exlex_pkg::CH_BANG;
      12: return exlex_pkg::CH_GT;
      default: return exlex_pkg::CH_LT;
    endcase
  endfunction

  function automatic logic [exlex_pkg::CharW-1:0] random_bad_byte();
    case ($urandom_range(3))
      0:       return exlex_pkg::CharW'($urandom_range(255, 128));
      1:       return exlex_pkg::CharW'($urandom_range(8));
      2:       return 8'h23;
      default: return (($urandom_range(1)) ? 8'h2E : 8'h40);
    endcase
  endfunction

  // Send one lexeme-shaped piece of text, or noise, or an end request
  task automatic send_fragment();
    int pick;
    int n;
    logic [exlex_pkg::CharW-1:0] c;
    pick = $urandom_range(99);
    if (pick < 25) begin
      send_char(random_letter());
      n = $urandom_range(5);
      repeat (n) send_char($urandom_range(2) ? random_letter() : random_digit());
    end else if (pick < 45) begin
      n = $urandom_range(5, 1);
      repeat (n) send_char(random_digit());
    end else if (pick < 65) begin
      c = random_op_lead();
      send_char(c);
      if ($urandom_range(1) &&
          ((c == exlex_pkg::CH_MINUS) || (c == exlex_pkg::CH_COLON) ||
           (c == exlex_pkg::CH_EQ) || (c == exlex_pkg::CH_BANG) ||
           (c == exlex_pkg::CH_GT) || (c == exlex_pkg::CH_LT))) begin
        send_char((c == exlex_pkg::CH_MINUS) ? exlex_pkg::CH_GT : exlex_pkg::CH_EQ);
      end
    end else if (pick < 80) begin
      n = $urandom_range(3, 1);
      repeat (n) send_char(random_blank());
    end else if (pick < 90) begin
      send_char(exlex_pkg::CharW'($urandom_range(255)));
    end else if (pick < 95) begin
      send_char(random_bad_byte());
    end else begin
      send_end();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every operator emitted at once and every paired operator, then close the stream
  task automatic test_operators();
    send_text("+*/{}(),->:===!=>=<=");
    send_end();
  endtask

  // Runs ended by blanks and by other bytes, invalid bytes, unpaired held operators
  task automatic test_runs_and_blanks();
    send_text("Zz9");
    for (int b = 9; b <= 13; b++) send_char(exlex_pkg::CharW'(b));
    send_text("09<");
    send_char(8'hFF);
    send_char(8'h00);
    send_text("--:");
    send_end();
  endtask

  // A long digit run ended by a blank, then an operator
  task automatic test_long_run();
    send_end();
    repeat (40) send_char(random_digit());
    send_text(" +");
    send_end();
  endtask

  task automatic test_random_text(input int unsigned sender_pct, input int unsigned receiver_pct,
                                  input int unsigned count);
    int unsigned goal;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    goal = requests_sent + count;
    while (requests_sent < goal) send_fragment();
    send_end();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each taken token with the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (lexed_tokens.size() == 0) begin
        $error("unexpected token: kind %0d start %0d length %0d",
               out_data.token_kind, out_data.token_start, out_data.token_length);
        mismatches++;
      end else begin
        oldest_token = lexed_tokens.pop_front();
        if (out_data.token_kind !== oldest_token.token_kind) begin
          $error("token_kind: expected %0d, got %0d",
                 oldest_token.token_kind, out_data.token_kind);
          mismatches++;
        end
        if (out_data.token_start !== oldest_token.token_start) begin
          $error("token_start: expected %0d, got %0d",
                 oldest_token.token_start, out_data.token_start);
          mismatches++;
        end
        if (out_data.token_length !== oldest_token.token_length) begin
          $error("token_length: expected %0d, got %0d",
                 oldest_token.token_length, out_data.token_length);
          mismatches++;
        end
        if (out_data.last_of_run !== oldest_token.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d",
                 oldest_token.last_of_run, out_data.last_of_run);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_expression_lexer: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 18;
    recv_idle_pct = 68;
    test_operators();
    test_runs_and_blanks();

    test_random_text(18, 68, 190);
    test_random_text(68, 18, 190);
    test_random_text(0, 0, 190);

    test_long_run();
    in_valid <= 1'b0;

    // Drain owed tokens, then give the block time to show any stray one
    while (lexed_tokens.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_expression_lexer: clean");
    end else begin
      $display("tb_expression_lexer: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/exlex_pkg.sv
sv/exlex_scan.sv
sv/exlex_fifo.sv
sv/expression_lexer.sv
tb/sv/tb_expression_lexer.sv
